/* design/awpi_pkg.sv */
// Shared types, widths, input codes and a helper function for the wind profile interpolator.
package awpi_pkg;

    localparam int MAX_KNOTS_DEF = 8;

    localparam int ALT_W     = 17;
    localparam int WIND_W    = 16;
    localparam int FOLD_W    = 19;
    localparam int BLEND_W   = 22;
    localparam int MUL_A_W   = 20;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SQ_IN_W   = 48;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 24;
    localparam int WGT_W     = 17;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic signed [ALT_W-1:0]  alt;
        logic signed [WIND_W-1:0] east;
        logic signed [WIND_W-1:0] north;
    } t_knot;

    // Clips a wide signed value into the Q8.8 output range.
    function automatic logic signed [WIND_W-1:0] sat16(input logic signed [BLEND_W-1:0] v);
        logic signed [WIND_W-1:0] r;
        if (v > BLEND_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -BLEND_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[WIND_W-1:0];
        end
        return r;
    endfunction

endpackage

/* design/altitude_wind_profile_interpolator_top.sv */
// Operation: clear, append and unused kinds finish in the idle state. A query walks
// the table, divides for the weight when two knots bracket the altitude, folds each
// chosen knot (a square root, then one division per component, the divisions skipped
// for a zero-length knot), then blends two folded knots and registers the result.
// Throughput: one transaction at a time; the input is ready only while the sequencer is idle.
// Reset: synchronous active low; count and control clear, table stays undefined.
module altitude_wind_profile_interpolator_top #(
    parameter int MAX_KNOTS = awpi_pkg::MAX_KNOTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_kind,
    input  logic signed [awpi_pkg::ALT_W-1:0]    i_altitude,
    input  logic signed [awpi_pkg::WIND_W-1:0]   i_knot_wind_east,
    input  logic signed [awpi_pkg::WIND_W-1:0]   i_knot_wind_north,
    input  logic signed [awpi_pkg::WIND_W-1:0]   i_gust_speed,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [awpi_pkg::WIND_W-1:0]   o_wind_east,
    output logic signed [awpi_pkg::WIND_W-1:0]   o_wind_north,
    output logic                                 o_table_empty
);
    import awpi_pkg::*;

    localparam int ADDR_W = $clog2(MAX_KNOTS);
    localparam int CNT_W  = ADDR_W + 1;

    // The sequencer walks the knot table through the memory read port, then
    // folds each chosen knot through the shared multiplier, the root unit and
    // the divider, and blends the two folded knots when two knots bracket the altitude.
    typedef enum logic [4:0] {
        ST_IDLE, ST_RD0, ST_CHK0, ST_CHKL, ST_WWAIT, ST_WCHK, ST_TDIV, ST_TWAIT,
        ST_FSQE, ST_FSQN, ST_FSUM, ST_FSQW, ST_FGE, ST_FDE, ST_FDWE, ST_FGN,
        ST_FDN, ST_FDWN, ST_FEND, ST_BLM, ST_BLE, ST_BLN, ST_DONE
    } t_state;

    typedef enum logic [1:0] {PH_SINGLE, PH_A, PH_B} t_phase;

    t_state                    r_state;
    t_phase                    r_phase;
    logic [CNT_W-1:0]          r_count;
    logic [ADDR_W-1:0]         r_addr;
    logic [ADDR_W-1:0]         r_idx;
    logic signed [ALT_W-1:0]   r_alt;
    logic signed [WIND_W-1:0]  r_g;
    t_knot                     r_prev;
    t_knot                     r_cur;
    logic [ALT_W:0]            r_span;
    logic [ALT_W-1:0]          r_woff;
    logic [WGT_W-1:0]          r_t;
    logic signed [WIND_W-1:0]  r_fold_e;
    logic signed [WIND_W-1:0]  r_fold_n;
    logic signed [FOLD_W-1:0]  r_fe;
    logic signed [FOLD_W-1:0]  r_fn;
    logic signed [FOLD_W-1:0]  r_fae;
    logic signed [FOLD_W-1:0]  r_fan;
    logic signed [PROD_W-1:0]  r_prod;
    logic [31:0]               r_sq;
    logic [SQ_OUT_W-1:0]       r_m;
    logic                      r_neg;
    logic signed [WIND_W-1:0]  r_res_e;
    logic signed [WIND_W-1:0]  r_res_n;
    logic                      r_res_empty;
    logic                      r_ov;
    logic signed [WIND_W-1:0]  r_oe;
    logic signed [WIND_W-1:0]  r_on;
    logic                      r_oempty;

    logic                      in_acc;
    logic                      mem_we;
    t_knot                     mem_wdata;
    t_knot                     rd;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      sq_start;
    logic [SQ_IN_W-1:0]        sq_in;
    logic                      sq_done;
    logic [SQ_OUT_W-1:0]       sq_root;
    logic                      div_start;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_DEN_W-1:0]      div_den;
    logic                      div_done;
    logic [DIV_NUM_W-1:0]      div_q;
    logic [PROD_W-1:0]         prod_mag;
    logic signed [FOLD_W-1:0]  q_signed;
    logic signed [BLEND_W-1:0] blend_step;
    logic signed [BLEND_W-1:0] blend_sum;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Appends go straight into the table as the transaction is accepted, unless it is full.
    assign mem_we          = in_acc && (i_kind == KIND_APPEND) && (r_count < CNT_W'(MAX_KNOTS));
    assign mem_wdata.alt   = i_altitude;
    assign mem_wdata.east  = i_knot_wind_east;
    assign mem_wdata.north = i_knot_wind_north;

    awpi_knot_mem #(.DEPTH(MAX_KNOTS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd)
    );

    awpi_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_in),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    awpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // One shared multiplier: squares, gust products and blend products.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_FSQE: begin
                mul_a = MUL_A_W'(r_fold_e);
                mul_b = MUL_B_W'(r_fold_e);
            end
            ST_FSQN: begin
                mul_a = MUL_A_W'(r_fold_n);
                mul_b = MUL_B_W'(r_fold_n);
            end
            ST_FGE: begin
                mul_a = MUL_A_W'(r_g);
                mul_b = MUL_B_W'(r_fold_e);
            end
            ST_FGN: begin
                mul_a = MUL_A_W'(r_g);
                mul_b = MUL_B_W'(r_fold_n);
            end
            ST_BLM: begin
                mul_a = MUL_A_W'(r_fe) - MUL_A_W'(r_fae);
                mul_b = {1'b0, r_t};
            end
            ST_BLE: begin
                mul_a = MUL_A_W'(r_fn) - MUL_A_W'(r_fan);
                mul_b = {1'b0, r_t};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Magnitude of a gust product, for the unsigned divider.
    assign prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    always_comb begin
        sq_start  = (r_state == ST_FSUM);
        sq_in     = {r_sq + r_prod[31:0], 16'h0000};
        div_start = 1'b0;
        div_num   = '0;
        div_den   = r_m;
        case (r_state)
            ST_TDIV: begin
                div_start = (r_span != '0);
                div_num   = DIV_NUM_W'({r_woff, 16'h0000});
                div_den   = DIV_DEN_W'(r_span);
            end
            ST_FDE, ST_FDN: begin
                div_start = 1'b1;
                div_num   = {1'b0, prod_mag[30:0], 8'h00};
                div_den   = r_m;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign q_signed = r_neg ? -FOLD_W'(div_q[WGT_W-1:0]) : FOLD_W'(div_q[WGT_W-1:0]);

    // Blend product divided by 65536 with truncation towards zero.
    assign blend_step = BLEND_W'(r_prod >>> 16)
                        + BLEND_W'(r_prod[PROD_W-1] && (r_prod[15:0] != 16'h0000));
    assign blend_sum  = (r_state == ST_BLE) ? BLEND_W'(r_fae) + blend_step
                                            : BLEND_W'(r_fan) + blend_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_SINGLE;
            r_count  <= '0;
            r_addr   <= '0;
            r_idx    <= '0;
            r_ov     <= 1'b0;
            r_oempty <= 1'b0;
        end else begin
            r_prod <= mul_p;
            // The hand-over in ST_DONE decides the output valid on its own.
            if (r_ov && i_out_ready && (r_state != ST_DONE)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_alt <= i_altitude;
                        r_g   <= i_gust_speed;
                        unique case (i_kind)
                            KIND_CLEAR: r_count <= '0;
                            KIND_APPEND: begin
                                if (mem_we) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            KIND_QUERY: begin
                                if (r_count == '0) begin
                                    r_res_e     <= '0;
                                    r_res_n     <= '0;
                                    r_res_empty <= 1'b1;
                                    r_state     <= ST_DONE;
                                end else begin
                                    r_addr  <= '0;
                                    r_state <= ST_RD0;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_RD0: begin
                    r_addr  <= ADDR_W'(r_count - 1'b1);
                    r_state <= ST_CHK0;
                end
                ST_CHK0: begin
                    r_prev <= rd;
                    if (r_alt <= rd.alt) begin
                        r_fold_e <= rd.east;
                        r_fold_n <= rd.north;
                        r_phase  <= PH_SINGLE;
                        r_state  <= ST_FSQE;
                    end else begin
                        r_state <= ST_CHKL;
                    end
                end
                ST_CHKL: begin
                    if (r_alt >= rd.alt) begin
                        r_fold_e <= rd.east;
                        r_fold_n <= rd.north;
                        r_phase  <= PH_SINGLE;
                        r_state  <= ST_FSQE;
                    end else begin
                        r_idx   <= '0;
                        r_addr  <= ADDR_W'(1);
                        r_state <= ST_WWAIT;
                    end
                end
                ST_WWAIT: r_state <= ST_WCHK;
                ST_WCHK: begin
                    if ((r_alt >= r_prev.alt) && (r_alt <= rd.alt)) begin
                        r_cur   <= rd;
                        r_span  <= (ALT_W+1)'(rd.alt) - (ALT_W+1)'(r_prev.alt);
                        r_woff  <= ALT_W'(r_alt - r_prev.alt);
                        r_state <= ST_TDIV;
                    end else if (CNT_W'(r_idx) + CNT_W'(2) == r_count) begin
                        // No segment brackets the altitude: answer with the last knot.
                        r_fold_e <= rd.east;
                        r_fold_n <= rd.north;
                        r_phase  <= PH_SINGLE;
                        r_state  <= ST_FSQE;
                    end else begin
                        r_prev  <= rd;
                        r_idx   <= r_idx + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= ST_WWAIT;
                    end
                end
                ST_TDIV: begin
                    if (r_span == '0) begin
                        r_t      <= '0;
                        r_fold_e <= r_prev.east;
                        r_fold_n <= r_prev.north;
                        r_phase  <= PH_A;
                        r_state  <= ST_FSQE;
                    end else begin
                        r_state <= ST_TWAIT;
                    end
                end
                ST_TWAIT: begin
                    if (div_done) begin
                        r_t      <= div_q[WGT_W-1:0];
                        r_fold_e <= r_prev.east;
                        r_fold_n <= r_prev.north;
                        r_phase  <= PH_A;
                        r_state  <= ST_FSQE;
                    end
                end
                ST_FSQE: r_state <= ST_FSQN;
                ST_FSQN: begin
                    r_sq    <= r_prod[31:0];
                    r_state <= ST_FSUM;
                end
                ST_FSUM: r_state <= ST_FSQW;
                ST_FSQW: begin
                    if (sq_done) begin
                        r_m <= sq_root;
                        if (sq_root == '0) begin
                            // A zero-length vector is left as it is.
                            r_fe    <= FOLD_W'(r_fold_e);
                            r_fn    <= FOLD_W'(r_fold_n);
                            r_state <= ST_FEND;
                        end else begin
                            r_state <= ST_FGE;
                        end
                    end
                end
                ST_FGE: r_state <= ST_FDE;
                ST_FDE: begin
                    r_neg   <= r_prod[PROD_W-1];
                    r_state <= ST_FDWE;
                end
                ST_FDWE: begin
                    if (div_done) begin
                        r_fe    <= FOLD_W'(r_fold_e) + q_signed;
                        r_state <= ST_FGN;
                    end
                end
                ST_FGN: r_state <= ST_FDN;
                ST_FDN: begin
                    r_neg   <= r_prod[PROD_W-1];
                    r_state <= ST_FDWN;
                end
                ST_FDWN: begin
                    if (div_done) begin
                        r_fn    <= FOLD_W'(r_fold_n) + q_signed;
                        r_state <= ST_FEND;
                    end
                end
                ST_FEND: begin
                    unique case (r_phase)
                        PH_SINGLE: begin
                            r_res_e     <= sat16(BLEND_W'(r_fe));
                            r_res_n     <= sat16(BLEND_W'(r_fn));
                            r_res_empty <= 1'b0;
                            r_state     <= ST_DONE;
                        end
                        PH_A: begin
                            r_fae    <= r_fe;
                            r_fan    <= r_fn;
                            r_fold_e <= r_cur.east;
                            r_fold_n <= r_cur.north;
                            r_phase  <= PH_B;
                            r_state  <= ST_FSQE;
                        end
                        default: r_state <= ST_BLM;
                    endcase
                end
                ST_BLM: r_state <= ST_BLE;
                ST_BLE: begin
                    r_res_e <= sat16(blend_sum);
                    r_state <= ST_BLN;
                end
                ST_BLN: begin
                    r_res_n     <= sat16(blend_sum);
                    r_res_empty <= 1'b0;
                    r_state     <= ST_DONE;
                end
                ST_DONE: begin
                    // The result waits here until the output register is free.
                    if (!r_ov || i_out_ready) begin
                        r_ov     <= 1'b1;
                        r_oe     <= r_res_e;
                        r_on     <= r_res_n;
                        r_oempty <= r_res_empty;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_ov;
    assign o_wind_east   = r_oe;
    assign o_wind_north  = r_on;
    assign o_table_empty = r_oempty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KNOTS))
        else $error("knot count exceeds table depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_empty) |-> (o_wind_east == '0 && o_wind_north == '0))
        else $error("empty-table result carries non-zero wind");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_TWAIT || r_state == ST_FDWE || r_state == ST_FDWN))
        else $error("divider finished with no state waiting for it");

    a_sqrt_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == ST_FSQW))
        else $error("root unit finished with no state waiting for it");
`endif

endmodule

/* design/awpi_knot_mem.sv */
// Knot table memory: one write port, one registered read port.
module awpi_knot_mem #(
    parameter int DEPTH = awpi_pkg::MAX_KNOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  awpi_pkg::t_knot          i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output awpi_pkg::t_knot          o_rdata
);
    import awpi_pkg::*;

    t_knot r_mem [DEPTH];
    t_knot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/awpi_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
module awpi_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [awpi_pkg::SQ_IN_W-1:0]  i_radicand,
    output logic                          o_done,
    output logic [awpi_pkg::SQ_OUT_W-1:0] o_root
);
    import awpi_pkg::*;

    localparam int REM_W = SQ_OUT_W + 3;
    localparam int CNT_W = $clog2(SQ_OUT_W + 1);

    logic [SQ_IN_W-1:0]  r_x;
    logic [REM_W-1:0]    r_rem;
    logic [SQ_OUT_W-1:0] r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [REM_W-1:0]    rem2;
    logic [REM_W-1:0]    trial;

    assign rem2  = {r_rem[REM_W-3:0], r_x[SQ_IN_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SQ_OUT_W);
                r_x    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_x <= {r_x[SQ_IN_W-3:0], 2'b00};
                if (rem2 >= trial) begin
                    r_rem  <= rem2 - trial;
                    r_root <= {r_root[SQ_OUT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem2;
                    r_root <= {r_root[SQ_OUT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* design/awpi_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module awpi_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [awpi_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [awpi_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic [awpi_pkg::DIV_NUM_W-1:0] o_quot
);
    import awpi_pkg::*;

    localparam int REM_W = DIV_DEN_W + 1;
    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] r_q;
    logic [REM_W-1:0]     r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [REM_W-1:0]     rem2;

    assign rem2 = {r_rem[REM_W-2:0], r_q[DIV_NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (rem2 >= {1'b0, r_den}) begin
                    r_rem <= rem2 - {1'b0, r_den};
                    r_q   <= {r_q[DIV_NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_q   <= {r_q[DIV_NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* test/wind_profile_checker.sv */
`timescale 1ns / 1ps
// Predicts and checks the wind profile interpolator's query answers.
module wind_profile_checker #(
    parameter int MAX_KNOTS = awpi_pkg::MAX_KNOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [1:0]                          i_kind,
    input  logic signed [awpi_pkg::ALT_W-1:0]   i_altitude,
    input  logic signed [awpi_pkg::WIND_W-1:0]  i_knot_wind_east,
    input  logic signed [awpi_pkg::WIND_W-1:0]  i_knot_wind_north,
    input  logic signed [awpi_pkg::WIND_W-1:0]  i_gust_speed,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [awpi_pkg::WIND_W-1:0]  i_wind_east,
    input  logic signed [awpi_pkg::WIND_W-1:0]  i_wind_north,
    input  logic                                i_table_empty,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import awpi_pkg::*;

    typedef struct packed {
        logic signed [WIND_W-1:0] east;
        logic signed [WIND_W-1:0] north;
        logic                     empty;
    } t_wind_answer;

    longint       knot_alt   [MAX_KNOTS];
    longint       knot_east  [MAX_KNOTS];
    longint       knot_north [MAX_KNOTS];
    int           stored_knots;
    t_wind_answer expected_winds[$];

    initial begin
        o_fail_count = 0;
        stored_knots = 0;
    end

    assign o_pending = expected_winds.size();

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Stretches one knot's vector by the gust along its own heading.
    task automatic gusted_knot(input int idx, input longint g,
                               output longint fe, output longint fn);
        longint e, n, m;
        e = knot_east[idx];
        n = knot_north[idx];
        m = longint'(int_sqrt(longint'(e * e + n * n) << 16));
        if (m == 0) begin
            fe = e;
            fn = n;
        end else begin
            fe = e + (g * e * 256) / m;
            fn = n + (g * n * 256) / m;
        end
    endtask

    function automatic logic signed [WIND_W-1:0] clip_q88(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[WIND_W-1:0];
    endfunction

    task automatic predict_wind(input longint alt, input longint g);
        t_wind_answer ans;
        longint we, wn, ae, an, be, bn, a, b, span, t;
        int last;
        bit done;
        ans = '0;
        if (stored_knots == 0) begin
            ans.empty = 1'b1;
        end else begin
            last = stored_knots - 1;
            done = 0;
            if (alt <= knot_alt[0]) begin
                gusted_knot(0, g, we, wn);
                done = 1;
            end else if (alt >= knot_alt[last]) begin
                gusted_knot(last, g, we, wn);
                done = 1;
            end else begin
                // Unordered tables may match no segment; the last knot answers then.
                for (int i = 0; i < last && !done; i++) begin
                    a = knot_alt[i];
                    b = knot_alt[i+1];
                    if (alt >= a && alt <= b) begin
                        span = b - a;
                        t = (span > 0) ? ((alt - a) * 65536) / span : 0;
                        gusted_knot(i, g, ae, an);
                        gusted_knot(i + 1, g, be, bn);
                        we = ae + ((be - ae) * t) / 65536;
                        wn = an + ((bn - an) * t) / 65536;
                        done = 1;
                    end
                end
                if (!done) gusted_knot(last, g, we, wn);
            end
            ans.east  = clip_q88(we);
            ans.north = clip_q88(wn);
        end
        expected_winds.insert(expected_winds.size(), ans);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_knots = 0;
            expected_winds.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_winds.size() == 0) begin
                    report_mismatch("answer with no query outstanding");
                end else begin
                    t_wind_answer exp_ans;
                    exp_ans = expected_winds.pop_front();
                    if (i_wind_east !== exp_ans.east)
                        report_mismatch($sformatf("wind_east %0d, expected %0d",
                                                  i_wind_east, exp_ans.east));
                    if (i_wind_north !== exp_ans.north)
                        report_mismatch($sformatf("wind_north %0d, expected %0d",
                                                  i_wind_north, exp_ans.north));
                    if (i_table_empty !== exp_ans.empty)
                        report_mismatch($sformatf("table_empty %0b, expected %0b",
                                                  i_table_empty, exp_ans.empty));
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_kind)
                    KIND_CLEAR: stored_knots = 0;
                    KIND_APPEND: begin
                        if (stored_knots < MAX_KNOTS) begin
                            knot_alt[stored_knots]   = i_altitude;
                            knot_east[stored_knots]  = i_knot_wind_east;
                            knot_north[stored_knots] = i_knot_wind_north;
                            stored_knots++;
                        end
                    end
                    KIND_QUERY: predict_wind(i_altitude, i_gust_speed);
                    default: ;
                endcase
            end
        end
    end
endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Top of the wind profile interpolator test: stimulus, reset, watchdog and verdict.
module testbench;
    import awpi_pkg::*;

    // The package names no code for the spare kind, which the block must ignore.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_TRANSACTIONS = 1350;
    // The limit is taken well beyond the time a query needs to walk and fold two
    // knots, and well beyond the receiver's long hold-off.
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 700;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               kind = KIND_CLEAR;
    logic signed [ALT_W-1:0]  altitude = '0;
    logic signed [WIND_W-1:0] knot_east = '0;
    logic signed [WIND_W-1:0] knot_north = '0;
    logic signed [WIND_W-1:0] gust = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [WIND_W-1:0] wind_east;
    logic signed [WIND_W-1:0] wind_north;
    logic                     table_empty;
    int                       fail_count;
    int                       pending;

    // Idling switches for both sides; the hold request makes the receiver stall
    // for a long stretch while the sender keeps offering transactions.
    bit sender_idles = 1'b0;
    bit receiver_idles = 1'b0;
    bit hold_request = 1'b0;
    int sent = 0;

    always #5 clk = ~clk;

    altitude_wind_profile_interpolator_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_kind(kind), .i_altitude(altitude),
        .i_knot_wind_east(knot_east), .i_knot_wind_north(knot_north),
        .i_gust_speed(gust),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_wind_east(wind_east), .o_wind_north(wind_north),
        .o_table_empty(table_empty)
    );

    wind_profile_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_kind(kind), .i_altitude(altitude),
        .i_knot_wind_east(knot_east), .i_knot_wind_north(knot_north),
        .i_gust_speed(gust),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_wind_east(wind_east), .i_wind_north(wind_north),
        .i_table_empty(table_empty),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: ready drops at random when idling is on, and stays low for a
    // counted stretch when a hold is requested.
    always @(posedge clk) begin
        if (hold_request) begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_request = 1'b0;
        end else begin
            out_ready <= !(receiver_idles && $urandom_range(99) < 23);
        end
    end

    // Watchdog: ends the run when nothing is accepted for too long.
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one transaction and waits for it to be accepted. Valid stays high
    // into the next transaction unless an idle cycle is drawn.
    task automatic send(input logic [1:0] k, input int alt_m, input int e,
                        input int n, input int g);
        while (sender_idles && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        altitude   <= ALT_W'(alt_m);
        knot_east  <= WIND_W'(e);
        knot_north <= WIND_W'(n);
        gust       <= WIND_W'(g);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    function automatic int any_wind();
        return $signed(16'($urandom));
    endfunction

    // Wind values are mostly moderate so that the blend stays in range, with
    // the full 16-bit range drawn now and then to reach saturation.
    function automatic int some_wind();
        if ($urandom_range(3) == 0) return any_wind();
        return $signed(16'($urandom_range(0, 8191))) - 4096;
    endfunction

    // One profile: clear, mostly ascending knots, several queries and now and then a spare kind.
    task automatic random_profile();
        int count, alt_m, lo, hi, queries;
        bit shuffle;
        count   = $urandom_range(1, 9);
        shuffle = ($urandom_range(9) == 0);
        alt_m   = $signed(17'($urandom));
        if ($urandom_range(1)) alt_m = $urandom_range(0, 2000) - 1000;
        lo = alt_m;
        send(KIND_CLEAR, $signed(17'($urandom)), any_wind(), any_wind(), any_wind());
        for (int i = 0; i < count; i++) begin
            send(KIND_APPEND, alt_m, some_wind(),
                 ($urandom_range(7) == 0) ? 0 : some_wind(), any_wind());
            if (shuffle)
                alt_m = $signed(17'($urandom));
            else if ($urandom_range(7) == 0)
                alt_m = alt_m;  // repeated altitude: zero span
            else if (alt_m < 60000)
                alt_m = alt_m + $urandom_range(1, 4000);
        end
        hi = alt_m;
        queries = $urandom_range(2, 8);
        for (int q = 0; q < queries; q++) begin
            case ($urandom_range(5))
                0: alt_m = $signed(17'($urandom));
                1: alt_m = lo;
                default: alt_m = lo + $urandom_range(0, (hi > lo) ? hi - lo : 0);
            endcase
            send(KIND_QUERY, alt_m, any_wind(), any_wind(), some_wind());
        end
        if ($urandom_range(9) == 0)
            send(KIND_SPARE, $signed(17'($urandom)), any_wind(), any_wind(), any_wind());
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, clamping, zero span, zero vector,
        // a full table, the spare kind and the extremes of every field.
        send(KIND_QUERY, 0, 0, 0, 256);
        send(KIND_APPEND, -65536, 16'sh7fff, 16'sh8000, 0);
        send(KIND_APPEND, -100, 0, 0, 0);
        send(KIND_APPEND, -100, 512, -512, 0);
        send(KIND_APPEND, 500, -32768, 32767, 0);
        send(KIND_QUERY, -65536, 0, 0, 32767);
        send(KIND_QUERY, -100, 0, 0, -32768);
        send(KIND_QUERY, 200, 0, 0, 0);
        send(KIND_QUERY, 65535, 0, 0, 32767);
        send(KIND_SPARE, 65535, -1, -1, -1);
        send(KIND_APPEND, 1000, 100, 100, 0);
        send(KIND_APPEND, 2000, 200, 0, 0);
        send(KIND_APPEND, 3000, 0, -300, 0);
        send(KIND_APPEND, 4000, -400, 0, 0);
        send(KIND_APPEND, 5000, 1, 1, 0);
        send(KIND_QUERY, 4500, 0, 0, -1);
        send(KIND_QUERY, -50, 0, 0, 128);
        send(KIND_CLEAR, 0, 0, 0, 0);
        send(KIND_QUERY, 12345, 0, 0, 0);
        send(KIND_APPEND, 65535, 32767, 32767, 0);
        send(KIND_QUERY, 0, 0, 0, 32767);

        // A first stretch with no idling on either side, then random idling, then a long hold.
        while (sent < 300) random_profile();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        while (sent < 700) random_profile();
        hold_request = 1'b1;
        while (sent < RANDOM_TRANSACTIONS) random_profile();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* sim.f */
design/awpi_pkg.sv
design/awpi_knot_mem.sv
design/awpi_sqrt.sv
design/awpi_div.sv
design/altitude_wind_profile_interpolator_top.sv
test/wind_profile_checker.sv
test/testbench.sv
